@@ rtl/core/tte_pkg.sv @@
`timescale 1ns / 1ps

package tte_pkg;

  // table geometry
  localparam int unsigned INDEX_BITS = 10;
  localparam int unsigned SLOT_COUNT = 1 << INDEX_BITS;

  // field widths
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned MOVE_W  = 16;
  localparam int unsigned BOUND_W = 2;
  localparam int unsigned GEN_W   = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // opcodes
  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_STORE = 1'b1;

  // bound kinds
  localparam logic [BOUND_W-1:0] BOUND_NONE  = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;
  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EVAL_ABSENT = 2'd2;

  // register reset values
  localparam logic [GEN_W-1:0]   GEN_RESET         = 6'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RESET = 8'h7F;
  localparam logic [SCORE_W-1:0] EVAL_ABSENT_RESET = 16'h7FFF;

  // controller to datapath commands
  typedef struct packed {
    logic                  accept;
    logic                  store_we;
    logic                  out_load;
    logic                  clear_we;
    logic [INDEX_BITS-1:0] clear_addr;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_store;
  } status_t;

endpackage

@@ rtl/core/tte_ctrl.sv @@
`timescale 1ns / 1ps

module tte_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tte_pkg::status_t status_i,
  output tte_pkg::cmd_t    cmd_o
);
  import tte_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                state_q, state_d;
  logic [INDEX_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o            = '0;
    cmd_o.clear_addr = clr_cnt_q;
    in_ready_o       = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.op_store) begin
          cmd_o.store_we = 1'b1;
          state_d = ST_IDLE;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/tte_datapath.sv @@
`timescale 1ns / 1ps

module tte_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tte_pkg::cmd_t                       cmd_i,
  output tte_pkg::status_t                    status_o,
  input  logic                                cfg_we_i,
  input  logic [tte_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tte_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                opcode_i,
  input  logic [tte_pkg::KEY_W-1:0]           position_key_i,
  input  logic signed [tte_pkg::DEPTH_W-1:0]  search_depth_i,
  input  logic signed [tte_pkg::SCORE_W-1:0]  score_value_i,
  input  logic [tte_pkg::BOUND_W-1:0]         bound_kind_i,
  input  logic [tte_pkg::MOVE_W-1:0]          best_move_i,
  input  logic signed [tte_pkg::SCORE_W-1:0]  static_eval_i,
  output logic                                hit_o,
  output logic signed [tte_pkg::SCORE_W-1:0]  entry_score_o,
  output logic signed [tte_pkg::SCORE_W-1:0]  entry_eval_o,
  output logic [tte_pkg::MOVE_W-1:0]          entry_move_o,
  output logic signed [tte_pkg::DEPTH_W-1:0]  entry_depth_o,
  output logic [tte_pkg::BOUND_W-1:0]         entry_bound_o,
  output logic [tte_pkg::GEN_W-1:0]           entry_generation_o
);
  import tte_pkg::*;

  // slot memory: check word above payload word
  logic [KEY_W+WORD_W-1:0] mem_q [SLOT_COUNT];
  logic [KEY_W+WORD_W-1:0] rd_q;

  // configuration
  logic [GEN_W-1:0]          gen_q;
  logic signed [DEPTH_W-1:0] depth_limit_q;
  logic signed [SCORE_W-1:0] eval_absent_q;

  // latched beat
  logic                      op_q;
  logic [KEY_W-1:0]          key_q;
  logic signed [DEPTH_W-1:0] depth_q;
  logic signed [SCORE_W-1:0] score_q;
  logic [BOUND_W-1:0]        bound_q;
  logic [MOVE_W-1:0]         move_q;
  logic signed [SCORE_W-1:0] eval_q;

  // stored slot fields
  logic [WORD_W-1:0]         s_word;
  logic [KEY_W-1:0]          s_check;
  logic signed [SCORE_W-1:0] s_score;
  logic signed [SCORE_W-1:0] s_eval;
  logic [MOVE_W-1:0]         s_move;
  logic signed [DEPTH_W-1:0] s_depth;
  logic [BOUND_W-1:0]        s_bound;
  logic [GEN_W-1:0]          s_gen;
  logic                      same_key;
  logic                      hit;

  // new entry
  logic signed [DEPTH_W-1:0] n_depth;
  logic [MOVE_W-1:0]         n_move;
  logic signed [SCORE_W-1:0] n_eval;
  logic [WORD_W-1:0]         n_word;
  logic                      replace;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q         <= GEN_RESET;
      depth_limit_q <= DEPTH_LIMIT_RESET;
      eval_absent_q <= EVAL_ABSENT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GENERATION:  gen_q         <= cfg_data_i[GEN_W-1:0];
        CFG_DEPTH_LIMIT: depth_limit_q <= cfg_data_i[DEPTH_W-1:0];
        CFG_EVAL_ABSENT: eval_absent_q <= cfg_data_i[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  // beat capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= opcode_i;
      key_q   <= position_key_i;
      depth_q <= search_depth_i;
      score_q <= score_value_i;
      bound_q <= bound_kind_i;
      move_q  <= best_move_i;
      eval_q  <= static_eval_i;
    end
  end

  // slot memory read and write
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= mem_q[position_key_i[INDEX_BITS-1:0]];
    end
    if (cmd_i.clear_we) begin
      mem_q[cmd_i.clear_addr] <= '0;
    end else if (cmd_i.store_we && replace) begin
      mem_q[key_q[INDEX_BITS-1:0]] <= {key_q ^ n_word, n_word};
    end
  end

  // unpack stored slot
  assign s_word   = rd_q[WORD_W-1:0];
  assign s_check  = rd_q[KEY_W+WORD_W-1:WORD_W];
  assign s_score  = s_word[15:0];
  assign s_eval   = s_word[31:16];
  assign s_move   = s_word[47:32];
  assign s_depth  = s_word[55:48];
  assign s_bound  = s_word[57:56];
  assign s_gen    = s_word[63:58];
  assign same_key = (s_check ^ s_word) == key_q;
  assign hit      = same_key && (s_bound != BOUND_NONE);

  // replacement decision and new entry
  always_comb begin
    n_depth = (depth_q > depth_limit_q) ? depth_limit_q : depth_q;
    n_move  = (same_key && (move_q == '0)) ? s_move : move_q;
    n_eval  = (same_key && (eval_q == eval_absent_q)) ? s_eval : eval_q;
    n_word  = {gen_q, bound_q, n_depth, n_move, n_eval, score_q};
    replace = (s_bound == BOUND_NONE) || (s_gen != gen_q) || (n_depth >= s_depth) ||
              (same_key && (bound_q == BOUND_EXACT));
  end

  // probe result register, zeros on a miss
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      hit_o              <= hit;
      entry_score_o      <= hit ? s_score : '0;
      entry_eval_o       <= hit ? s_eval  : '0;
      entry_move_o       <= hit ? s_move  : '0;
      entry_depth_o      <= hit ? s_depth : '0;
      entry_bound_o      <= hit ? s_bound : '0;
      entry_generation_o <= hit ? s_gen   : '0;
    end
  end

  assign status_o.op_store = (op_q == OP_STORE);

endmodule

@@ rtl/core/transposition_table_engine.sv @@
`timescale 1ns / 1ps

// Direct-mapped transposition table of 2^INDEX_BITS slots (1024), each a payload word and
// a check word in one synchronous single-port memory. An item's accept cycle issues the
// slot read; the next cycle compares the key and either writes the slot back if the
// replacement rule allows (store) or loads the output register (probe). A probe result
// waits in the output register while the next item is taken; a probe behind an untaken
// result holds in its compare state until the output register frees. After reset, a
// clearing pass zeroes all 1024 slots one slot a cycle with in_ready_o low; configuration
// beats are accepted at any time (cfg_ready_o is always high) and indexes beyond 2 are ignored.
module transposition_table_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tte_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tte_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic [tte_pkg::KEY_W-1:0]           position_key_i,
  input  logic signed [tte_pkg::DEPTH_W-1:0]  search_depth_i,
  input  logic signed [tte_pkg::SCORE_W-1:0]  score_value_i,
  input  logic [tte_pkg::BOUND_W-1:0]         bound_kind_i,
  input  logic [tte_pkg::MOVE_W-1:0]          best_move_i,
  input  logic signed [tte_pkg::SCORE_W-1:0]  static_eval_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic signed [tte_pkg::SCORE_W-1:0]  entry_score_o,
  output logic signed [tte_pkg::SCORE_W-1:0]  entry_eval_o,
  output logic [tte_pkg::MOVE_W-1:0]          entry_move_o,
  output logic signed [tte_pkg::DEPTH_W-1:0]  entry_depth_o,
  output logic [tte_pkg::BOUND_W-1:0]         entry_bound_o,
  output logic [tte_pkg::GEN_W-1:0]           entry_generation_o
);
  import tte_pkg::*;

  cmd_t    cmd;
  status_t status;

  // configuration port never stalls
  assign cfg_ready_o = 1'b1;

  // sequencer
  tte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // table, registers and result
  tte_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .opcode_i           (opcode_i),
    .position_key_i     (position_key_i),
    .search_depth_i     (search_depth_i),
    .score_value_i      (score_value_i),
    .bound_kind_i       (bound_kind_i),
    .best_move_i        (best_move_i),
    .static_eval_i      (static_eval_i),
    .hit_o              (hit_o),
    .entry_score_o      (entry_score_o),
    .entry_eval_o       (entry_eval_o),
    .entry_move_o       (entry_move_o),
    .entry_depth_o      (entry_depth_o),
    .entry_bound_o      (entry_bound_o),
    .entry_generation_o (entry_generation_o)
  );

endmodule

@@ tb/transposition_table_engine_tb.sv @@
`timescale 1ns / 1ps

module transposition_table_engine_tb;
  import tte_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_COUNT     = 8;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int POOL_SIZE       = 16;

  // index past the register list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [KEY_W-1:0] KEY_ZERO = '0;
  localparam logic [KEY_W-1:0] KEY_A    = '1;
  localparam logic [KEY_W-1:0] KEY_B    = 64'h8000_0000_0000_03FF;
  localparam logic [KEY_W-1:0] KEY_C    = 64'h0000_0000_0000_0001;
  localparam logic [KEY_W-1:0] KEY_D    = 64'h0000_0000_0000_0155;
  localparam logic [KEY_W-1:0] KEY_D2   = 64'h5A5A_0000_0000_0155;

  typedef struct {
    logic                     op;
    logic [KEY_W-1:0]         key;
    logic signed [DEPTH_W-1:0] depth;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]       bound;
    logic [MOVE_W-1:0]        move;
    logic signed [SCORE_W-1:0] eval;
  } tt_req_t;

  typedef struct {
    logic                     hit;
    logic signed [SCORE_W-1:0] score;
    logic signed [SCORE_W-1:0] eval;
    logic [MOVE_W-1:0]        move;
    logic signed [DEPTH_W-1:0] depth;
    logic [BOUND_W-1:0]       bound;
    logic [GEN_W-1:0]         gen;
  } tt_entry_t;

  // slot payload word, msb first
  typedef struct packed {
    logic [GEN_W-1:0]   gen;
    logic [BOUND_W-1:0] bound;
    logic [DEPTH_W-1:0] depth;
    logic [MOVE_W-1:0]  move;
    logic [SCORE_W-1:0] eval;
    logic [SCORE_W-1:0] score;
  } slot_word_t;

  typedef struct {
    logic                  is_cfg;
    tt_req_t               req;
    logic                  typed;
    tt_entry_t             want;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic opcode_i;
  logic [KEY_W-1:0] position_key_i;
  logic signed [DEPTH_W-1:0] search_depth_i;
  logic signed [SCORE_W-1:0] score_value_i;
  logic [BOUND_W-1:0] bound_kind_i;
  logic [MOVE_W-1:0] best_move_i;
  logic signed [SCORE_W-1:0] static_eval_i;
  logic out_valid_o;
  logic out_ready_i;
  logic hit_o;
  logic signed [SCORE_W-1:0] entry_score_o;
  logic signed [SCORE_W-1:0] entry_eval_o;
  logic [MOVE_W-1:0] entry_move_o;
  logic signed [DEPTH_W-1:0] entry_depth_o;
  logic [BOUND_W-1:0] entry_bound_o;
  logic [GEN_W-1:0] entry_generation_o;

  // shadow table and registers
  logic [WORD_W-1:0] table_payload [SLOT_COUNT];
  logic [WORD_W-1:0] table_check [SLOT_COUNT];
  logic [GEN_W-1:0] cur_gen;
  logic signed [DEPTH_W-1:0] depth_lim;
  logic signed [SCORE_W-1:0] eval_absent;

  tt_entry_t pending_probes [$];
  tt_entry_t got_want;
  row_t directed [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  tt_req_t rand_req;

  int mismatch_count;
  int stuck_cycles;
  int idle_pct;
  int stall_pct;
  logic [GEN_W-1:0] gen_v;
  logic [DEPTH_W-1:0] lim_v;
  logic [CFG_DATA_W-1:0] abs_v;

  transposition_table_engine dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .position_key_i    (position_key_i),
    .search_depth_i    (search_depth_i),
    .score_value_i     (score_value_i),
    .bound_kind_i      (bound_kind_i),
    .best_move_i       (best_move_i),
    .static_eval_i     (static_eval_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .hit_o             (hit_o),
    .entry_score_o     (entry_score_o),
    .entry_eval_o      (entry_eval_o),
    .entry_move_o      (entry_move_o),
    .entry_depth_o     (entry_depth_o),
    .entry_bound_o     (entry_bound_o),
    .entry_generation_o(entry_generation_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // probe lookup or depth-preferred store on the shadow table
  function automatic void table_access(tt_req_t r);
    logic [INDEX_BITS-1:0] slot;
    slot_word_t word;
    slot_word_t fresh;
    logic same;
    logic signed [DEPTH_W-1:0] held_depth;
    logic signed [DEPTH_W-1:0] clamped;
    tt_entry_t res;
    slot = r.key[INDEX_BITS-1:0];
    word = table_payload[slot];
    same = ((table_check[slot] ^ word) == r.key);
    if (r.op == OP_PROBE) begin
      res = '{default: '0};
      if (same && word.bound != BOUND_NONE) begin
        res.hit   = 1'b1;
        res.score = word.score;
        res.eval  = word.eval;
        res.move  = word.move;
        res.depth = word.depth;
        res.bound = word.bound;
        res.gen   = word.gen;
      end
      pending_probes.push_back(res);
    end else begin
      clamped = (r.depth > depth_lim) ? depth_lim : r.depth;
      held_depth = word.depth;
      if (word.bound == BOUND_NONE || word.gen != cur_gen || clamped >= held_depth ||
          (same && r.bound == BOUND_EXACT)) begin
        fresh.gen   = cur_gen;
        fresh.bound = r.bound;
        fresh.depth = clamped;
        // same key keeps the old move and eval when the new ones are missing
        fresh.move  = (r.move == '0 && same) ? word.move : r.move;
        fresh.eval  = (r.eval == eval_absent && same) ? word.eval : r.eval;
        fresh.score = r.score;
        table_payload[slot] = fresh;
        table_check[slot] = r.key ^ fresh;
      end
    end
  endfunction

  function automatic row_t item_row(logic op, logic [KEY_W-1:0] key,
                                    logic signed [DEPTH_W-1:0] depth,
                                    logic signed [SCORE_W-1:0] score,
                                    logic [BOUND_W-1:0] bound, logic [MOVE_W-1:0] move,
                                    logic signed [SCORE_W-1:0] eval);
    row_t row;
    row.is_cfg    = 1'b0;
    row.typed     = 1'b0;
    row.want      = '{default: '0};
    row.cfg_idx   = '0;
    row.cfg_data  = '0;
    row.req.op    = op;
    row.req.key   = key;
    row.req.depth = depth;
    row.req.score = score;
    row.req.bound = bound;
    row.req.move  = move;
    row.req.eval  = eval;
    return row;
  endfunction

  function automatic row_t probe_miss(logic [KEY_W-1:0] key);
    row_t row;
    row = item_row(OP_PROBE, key, '0, '0, BOUND_NONE, '0, '0);
    row.typed = 1'b1;
    return row;
  endfunction

  function automatic row_t probe_hit(logic [KEY_W-1:0] key, logic signed [SCORE_W-1:0] score,
                                     logic signed [SCORE_W-1:0] eval, logic [MOVE_W-1:0] move,
                                     logic signed [DEPTH_W-1:0] depth,
                                     logic [BOUND_W-1:0] bound, logic [GEN_W-1:0] gen);
    row_t row;
    row = probe_miss(key);
    row.want.hit   = 1'b1;
    row.want.score = score;
    row.want.eval  = eval;
    row.want.move  = move;
    row.want.depth = depth;
    row.want.bound = bound;
    row.want.gen   = gen;
    return row;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    row_t row;
    row = item_row(OP_PROBE, '0, '0, '0, BOUND_NONE, '0, '0);
    row.is_cfg   = 1'b1;
    row.cfg_idx  = idx;
    row.cfg_data = data;
    return row;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // one input beat, expectation recorded at the accepting edge
  task automatic send_item(tt_req_t r, logic typed, tt_entry_t want);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    opcode_i       = r.op;
    position_key_i = r.key;
    search_depth_i = r.depth;
    score_value_i  = r.score;
    bound_kind_i   = r.bound;
    best_move_i    = r.move;
    static_eval_i  = r.eval;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (typed) pending_probes.push_back(want);
    else table_access(r);
  endtask

  // drain all probe results, then let a trailing store finish
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_probes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_GENERATION:  cur_gen = data[GEN_W-1:0];
      CFG_DEPTH_LIMIT: depth_lim = data[DEPTH_W-1:0];
      CFG_EVAL_ABSENT: eval_absent = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // random item: mostly keys from a small pool crowded onto a few slots
  task automatic random_item(output tt_req_t r);
    int pick;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 9);
    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (pick == 7) key = key ^ (64'd1 << $urandom_range(INDEX_BITS, KEY_W - 1));
    else if (pick >= 8) key = {$urandom, $urandom};
    r.op  = 1'($urandom_range(0, 1));
    r.key = key;
    case ($urandom_range(0, 3))
      0: r.depth = 8'($urandom);
      1: r.depth = 8'(int'($urandom_range(0, 8)) - 4);
      2: r.depth = depth_lim + 8'(int'($urandom_range(0, 4)) - 2);
      default: r.depth = $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
    endcase
    r.score = 16'($urandom);
    r.bound = 2'($urandom);
    r.move  = ($urandom_range(0, 9) < 3) ? '0 : 16'($urandom);
    r.eval  = ($urandom_range(0, 9) < 3) ? eval_absent : 16'($urandom);
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= stall_pct);
  end

  // result check against the oldest pending probe
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_probes.size() == 0) begin
        report_mismatch("result beat with no probe pending");
      end else begin
        got_want = pending_probes.pop_front();
        check_field("hit", 16'(hit_o), 16'(got_want.hit));
        check_field("entry_score", entry_score_o, got_want.score);
        check_field("entry_eval", entry_eval_o, got_want.eval);
        check_field("entry_move", entry_move_o, got_want.move);
        check_field("entry_depth", 16'(entry_depth_o), 16'(got_want.depth));
        check_field("entry_bound", 16'(entry_bound_o), 16'(got_want.bound));
        check_field("entry_generation", 16'(entry_generation_o), 16'(got_want.gen));
      end
    end
  end

  // watchdog on beats of any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no beat for %0d cycles", stuck_cycles);
      $display("transposition_table_engine_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_PROBE;
    position_key_i = '0;
    search_depth_i = '0;
    score_value_i  = '0;
    bound_kind_i   = BOUND_NONE;
    best_move_i    = '0;
    static_eval_i  = '0;
    out_ready_i    = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    mismatch_count = 0;
    stuck_cycles   = 0;
    cur_gen        = GEN_RESET;
    depth_lim      = DEPTH_LIMIT_RESET;
    eval_absent    = EVAL_ABSENT_RESET;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      table_payload[i] = '0;
      table_check[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][INDEX_BITS-1:0] = INDEX_BITS'(i % 6);
    end

    // directed rows: empty table, extremes, rejection, same-key merge, clamp, generation
    directed.push_back(probe_miss(KEY_ZERO));
    directed.push_back(probe_miss(KEY_A));
    directed.push_back(item_row(OP_STORE, KEY_A, 8'sh7F, 16'sh8000, BOUND_EXACT,
                                16'hFFFF, 16'sh8000));
    directed.push_back(probe_hit(KEY_A, 16'sh8000, 16'sh8000, 16'hFFFF, 8'sh7F,
                                 BOUND_EXACT, 6'd0));
    directed.push_back(item_row(OP_STORE, KEY_B, 8'sd126, 16'sd100, BOUND_LOWER,
                                16'd1, 16'sd2));
    directed.push_back(probe_miss(KEY_B));
    directed.push_back(item_row(OP_PROBE, KEY_A, '0, '0, BOUND_NONE, '0, '0));
    directed.push_back(item_row(OP_STORE, KEY_A, 8'sh80, 16'sd5, BOUND_EXACT,
                                16'd0, 16'sh7FFF));
    directed.push_back(probe_hit(KEY_A, 16'sd5, 16'sh8000, 16'hFFFF, 8'sh80,
                                 BOUND_EXACT, 6'd0));
    directed.push_back(item_row(OP_STORE, KEY_C, 8'sd10, 16'sd3, BOUND_NONE,
                                16'd4, 16'sd5));
    directed.push_back(probe_miss(KEY_C));
    directed.push_back(item_row(OP_STORE, KEY_ZERO, 8'sd0, 16'sd1, BOUND_LOWER,
                                16'd0, 16'sh7FFF));
    directed.push_back(probe_hit(KEY_ZERO, 16'sd1, 16'sd0, 16'd0, 8'sd0,
                                 BOUND_LOWER, 6'd0));
    directed.push_back(cfg_row(CFG_DEPTH_LIMIT, 16'hA5FB));
    directed.push_back(item_row(OP_STORE, KEY_D, 8'sh7F, 16'sd7, BOUND_UPPER,
                                16'd3, 16'sd9));
    directed.push_back(probe_hit(KEY_D, 16'sd7, 16'sd9, 16'd3, -8'sd5, BOUND_UPPER, 6'd0));
    directed.push_back(cfg_row(CFG_GENERATION, 16'hFFFF));
    directed.push_back(item_row(OP_STORE, KEY_D2, 8'sh80, -16'sd1, BOUND_LOWER,
                                16'h8000, -16'sd7));
    directed.push_back(probe_hit(KEY_D2, -16'sd1, -16'sd7, 16'h8000, 8'sh80,
                                 BOUND_LOWER, 6'd63));
    directed.push_back(item_row(OP_PROBE, KEY_D, '0, '0, BOUND_NONE, '0, '0));
    directed.push_back(cfg_row(CFG_UNUSED, 16'h1234));
    directed.push_back(cfg_row(CFG_EVAL_ABSENT, 16'h8000));
    directed.push_back(item_row(OP_STORE, KEY_D2, 8'sh80, 16'sd42, BOUND_UPPER,
                                16'd0, 16'sh8000));
    directed.push_back(probe_hit(KEY_D2, 16'sd42, -16'sd7, 16'h8000, 8'sh80,
                                 BOUND_UPPER, 6'd63));

    // reset, then the block clears its table on its own
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle();
        write_reg(directed[i].cfg_idx, directed[i].cfg_data);
      end else begin
        send_item(directed[i].req, directed[i].typed, directed[i].want);
      end
    end
    settle();

    // random phases over register settings and idle patterns
    for (int p = 0; p < PHASE_COUNT; p++) begin
      gen_v = (p == 1) ? 6'd63 : (p == 2) ? 6'd0 : 6'($urandom);
      lim_v = (p == 1) ? 8'h80 : (p == 0 || p == 5) ? 8'h7F :
              8'(int'($urandom_range(0, 20)) - 6);
      abs_v = (p == 1) ? 16'h8000 : (p == 2) ? 16'h7FFF : 16'($urandom);
      write_reg(CFG_GENERATION, {10'($urandom), gen_v});
      write_reg(CFG_DEPTH_LIMIT, {8'($urandom), lim_v});
      write_reg(CFG_EVAL_ABSENT, abs_v);
      write_reg(CFG_UNUSED, 16'($urandom));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_item(rand_req);
        send_item(rand_req, 1'b0, '{default: '0});
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("transposition_table_engine_tb: done, clean");
    end else begin
      $display("transposition_table_engine_tb: done, errors");
    end
    $finish;
  end

endmodule
